// File: rtl/pgs_pkg.sv
// shared types and constants for the polar gaussian sampler
`timescale 1ns / 1ps
package pgs_pkg;

	// fixed-point layout
	localparam int LOG_FRAC   = 56;
	localparam int DIV_STEPS  = 63;
	localparam int MUL_STEPS  = 4;
	localparam logic [63:0] LN2_Q64 = 64'hB17217F7D1CF79AB;
	localparam logic [16:0] SPB_RESET = 17'd1024;

	// sequencer states, one-hot
	typedef enum logic [13:0] {
		ST_IDLE  = 14'b00000000000001,
		ST_SQ1   = 14'b00000000000010,
		ST_SQ2   = 14'b00000000000100,
		ST_CHECK = 14'b00000000001000,
		ST_NORM  = 14'b00000000010000,
		ST_LOGSQ = 14'b00000000100000,
		ST_TCALC = 14'b00000001000000,
		ST_LNMUL = 14'b00000010000000,
		ST_DIVI  = 14'b00000100000000,
		ST_DIV   = 14'b00001000000000,
		ST_SMUL  = 14'b00010000000000,
		ST_SQRT  = 14'b00100000000000,
		ST_FMT   = 14'b01000000000000,
		ST_OUTW  = 14'b10000000000000
	} pgs_state_t;

endpackage

// File: rtl/pgs_mul64.sv
// iterative 64x64 multiplier built on one registered 32x32 multiplier
`timescale 1ns / 1ps
module pgs_mul64 import pgs_pkg::*; (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         start,
	input  logic [63:0]  a,
	input  logic [63:0]  b,
	output logic         done,
	output logic [127:0] prod
);

	logic [63:0]  a_q, b_q;
	logic [2:0]   step_q;
	logic         busy_q, done_q, pp_vld_q;
	logic [1:0]   ppsel_q;
	logic [63:0]  pp_q;
	logic [127:0] acc_q;
	logic [31:0]  a_half, b_half;
	logic [127:0] pp_shifted;

	// operand halves for the current partial product
	assign a_half = step_q[1] ? a_q[63:32] : a_q[31:0];
	assign b_half = step_q[0] ? b_q[63:32] : b_q[31:0];

	// place the registered partial product
	always_comb begin
		unique case (ppsel_q)
			2'b00:   pp_shifted = {64'd0, pp_q};
			2'b01,
			2'b10:   pp_shifted = {32'd0, pp_q, 32'd0};
			default: pp_shifted = {pp_q, 64'd0};
		endcase
	end

	// control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q   <= 1'b0;
			done_q   <= 1'b0;
			pp_vld_q <= 1'b0;
			step_q   <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q   <= 1'b1;
				step_q   <= '0;
				pp_vld_q <= 1'b0;
			end else if (busy_q) begin
				pp_vld_q <= (step_q < 3'(MUL_STEPS));
				step_q   <= step_q + 3'd1;
				if (step_q == 3'(MUL_STEPS)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// partial products and accumulation
	always_ff @(posedge clk) begin
		if (start) begin
			a_q   <= a;
			b_q   <= b;
			acc_q <= '0;
		end else if (busy_q) begin
			pp_q    <= a_half * b_half;
			ppsel_q <= step_q[1:0];
			if (pp_vld_q) begin
				acc_q <= acc_q + pp_shifted;
			end
		end
	end

	assign done = done_q;
	assign prod = acc_q;

endmodule

// File: rtl/polar_gaussian_sampler.sv
// polar gaussian sampler top level: sequencer, datapath registers and block counter
`timescale 1ns / 1ps
// Takes a pair of 32-bit uniform fractions and, unless the pair falls outside
// the unit circle (or on its center), returns one or two normal samples in
// signed Q5.27, first from the first coordinate, then from the second. Per
// accepted pair the work is 56 log2 squarings, every one a 64x64 product taken
// as four partial products on the single shared 32x32 multiplier, plus a
// normalizing shift of up to 62 bit positions, and per sample a 63-step
// restoring divide, a 64x64 product and a 32-step square root. A rejected
// pair returns to idle with no result. The block takes no new pair until
// the last sample of the current one has been transferred out. A sample
// counter flags end_of_block on every samples_per_block-th sample; if that
// falls on the first sample of a pair, the second one is dropped.
module polar_gaussian_sampler import pgs_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_we,
	input  logic [16:0]        cfg_wdata,
	input  logic               uniform_valid,
	output logic               uniform_stall,
	input  logic [31:0]        uniform_first,
	input  logic [31:0]        uniform_second,
	output logic               sample_valid,
	input  logic               sample_stall,
	output logic signed [31:0] gauss_sample,
	output logic               end_of_block,
	output logic               last_of_item
);

	pgs_state_t state_q, state_d;

	logic [16:0]  spb_q, cnt_q;
	logic         sample_valid_q, mul_start_q;
	logic [63:0]  mul_a_q, mul_b_q;
	logic         mul_done;
	logic [127:0] mul_prod;

	logic [31:0]  a2_q;
	logic         neg1_q, neg2_q, sel_q;
	logic [63:0]  sq1_q, sq2_q, r_q, y_q, l_q, rem_q, n_q, res_q, bit_q;
	logic [5:0]   k_q, it_q;
	logic [55:0]  frac_q;
	logic [62:0]  q_q;
	logic [31:0]  sample_q;
	logic         eob_q, last_q;

	logic         in_xfer, out_xfer, r_bad, sq_top, div_ge, sq_ge, eob, neg;
	logic         log_last, div_last;
	logic [31:0]  a1, a2;
	logic [63:0]  y_next, sq_try;
	logic [62:0]  q_next;
	logic [32:0]  mag;
	logic [31:0]  sample_d;

	pgs_mul64 u_mul (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (mul_start_q),
		.a      (mul_a_q),
		.b      (mul_b_q),
		.done   (mul_done),
		.prod   (mul_prod)
	);

	// handshakes
	assign in_xfer  = uniform_valid && !uniform_stall;
	assign out_xfer = sample_valid && !sample_stall;

	// magnitude of v = 2u - 1 in units 2^-31
	assign a1 = uniform_first[31]  ? {1'b0, uniform_first[30:0]}  : 32'h80000000 - uniform_first;
	assign a2 = uniform_second[31] ? {1'b0, uniform_second[30:0]} : 32'h80000000 - uniform_second;

	// loop conditions and step values
	assign r_bad    = (r_q == 64'd0) || (r_q[63:62] != 2'b00);
	assign sq_top   = mul_prod[125];
	assign y_next   = sq_top ? mul_prod[126:63] : mul_prod[125:62];
	assign log_last = (it_q == 6'(LOG_FRAC - 1));
	assign div_ge   = (rem_q >= r_q);
	assign div_last = (it_q == 6'(DIV_STEPS - 1));
	assign q_next   = {q_q[61:0], div_ge};
	assign sq_try   = res_q + bit_q;
	assign sq_ge    = (n_q >= sq_try);
	assign eob      = ({1'b0, cnt_q} + 18'd1) >= {1'b0, spb_q};
	assign neg      = sel_q ? neg2_q : neg1_q;

	// round to 27 fraction bits, apply sign and saturate
	always_comb begin
		mag = 33'(({1'b0, res_q[32:0]} + 34'd1) >> 1);
		if (neg) begin
			sample_d = (mag > 33'h080000000) ? 32'h80000000 : 32'(33'd0 - mag);
		end else begin
			sample_d = (mag > 33'h07FFFFFFF) ? 32'h7FFFFFFF : mag[31:0];
		end
	end

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE:  if (in_xfer) state_d = ST_SQ1;
			ST_SQ1:   if (mul_done) state_d = ST_SQ2;
			ST_SQ2:   if (mul_done) state_d = ST_CHECK;
			ST_CHECK: state_d = r_bad ? ST_IDLE : ST_NORM;
			ST_NORM:  if (y_q[62]) state_d = ST_LOGSQ;
			ST_LOGSQ: if (mul_done && log_last) state_d = ST_TCALC;
			ST_TCALC: state_d = ST_LNMUL;
			ST_LNMUL: if (mul_done) state_d = ST_DIVI;
			ST_DIVI:  state_d = ST_DIV;
			ST_DIV:   if (div_last) state_d = ST_SMUL;
			ST_SMUL:  if (mul_done) state_d = ST_SQRT;
			ST_SQRT:  if (bit_q[0]) state_d = ST_FMT;
			ST_FMT:   state_d = ST_OUTW;
			ST_OUTW:  if (out_xfer) state_d = last_q ? ST_IDLE : ST_DIVI;
			default:  state_d = ST_IDLE;
		endcase
	end

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= ST_IDLE;
			spb_q          <= SPB_RESET;
			cnt_q          <= '0;
			sample_valid_q <= 1'b0;
			mul_start_q    <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cfg_we) begin
				spb_q <= cfg_wdata;
			end
			mul_start_q <= ((state_q == ST_IDLE) && in_xfer)
				|| ((state_q == ST_SQ1) && mul_done)
				|| ((state_q == ST_NORM) && y_q[62])
				|| ((state_q == ST_LOGSQ) && mul_done && !log_last)
				|| (state_q == ST_TCALC)
				|| ((state_q == ST_DIV) && div_last);
			if (state_q == ST_FMT) begin
				cnt_q          <= eob ? 17'd0 : cnt_q + 17'd1;
				sample_valid_q <= 1'b1;
			end else if (out_xfer) begin
				sample_valid_q <= 1'b0;
			end
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		unique case (state_q)
			ST_IDLE: begin
				if (in_xfer) begin
					a2_q    <= a2;
					neg1_q  <= !uniform_first[31];
					neg2_q  <= !uniform_second[31];
					mul_a_q <= {32'd0, a1};
					mul_b_q <= {32'd0, a1};
				end
			end
			ST_SQ1: begin
				if (mul_done) begin
					sq1_q   <= mul_prod[63:0];
					mul_a_q <= {32'd0, a2_q};
					mul_b_q <= {32'd0, a2_q};
				end
			end
			ST_SQ2: begin
				if (mul_done) begin
					sq2_q <= mul_prod[63:0];
					r_q   <= sq1_q + mul_prod[63:0];
				end
			end
			ST_CHECK: begin
				y_q <= r_q;
				k_q <= '0;
			end
			ST_NORM: begin
				if (y_q[62]) begin
					mul_a_q <= y_q;
					mul_b_q <= y_q;
					it_q    <= '0;
					frac_q  <= '0;
				end else begin
					y_q <= {y_q[62:0], 1'b0};
					k_q <= k_q + 6'd1;
				end
			end
			ST_LOGSQ: begin
				if (mul_done) begin
					frac_q  <= {frac_q[54:0], sq_top};
					y_q     <= y_next;
					mul_a_q <= y_next;
					mul_b_q <= y_next;
					it_q    <= it_q + 6'd1;
				end
			end
			ST_TCALC: begin
				mul_a_q <= {2'b00, k_q, 56'd0} - {8'd0, frac_q};
				mul_b_q <= LN2_Q64;
				sel_q   <= 1'b0;
			end
			ST_LNMUL: begin
				if (mul_done) begin
					l_q <= {mul_prod[126:64], 1'b0};
				end
			end
			ST_DIVI: begin
				rem_q <= sel_q ? sq2_q : sq1_q;
				q_q   <= '0;
				it_q  <= '0;
			end
			ST_DIV: begin
				q_q   <= q_next;
				rem_q <= {(div_ge ? rem_q - r_q : rem_q)} << 1;
				it_q  <= it_q + 6'd1;
				if (div_last) begin
					mul_a_q <= {1'b0, q_next};
					mul_b_q <= l_q;
				end
			end
			ST_SMUL: begin
				if (mul_done) begin
					n_q   <= mul_prod[125:62];
					res_q <= '0;
					bit_q <= 64'h4000000000000000;
				end
			end
			ST_SQRT: begin
				if (sq_ge) begin
					n_q   <= n_q - sq_try;
					res_q <= (res_q >> 1) + bit_q;
				end else begin
					res_q <= res_q >> 1;
				end
				bit_q <= bit_q >> 2;
			end
			ST_FMT: begin
				sample_q <= sample_d;
				eob_q    <= eob;
				last_q   <= eob || sel_q;
			end
			ST_OUTW: begin
				if (out_xfer && !last_q) begin
					sel_q <= 1'b1;
				end
			end
			default: begin
			end
		endcase
	end

	assign uniform_stall = (state_q != ST_IDLE);
	assign sample_valid  = sample_valid_q;
	assign gauss_sample  = sample_q;
	assign end_of_block  = eob_q;
	assign last_of_item  = last_q;

`ifndef SYNTHESIS
	// an output only waits in the transfer state
	assert property (@(posedge clk) disable iff (!arst_n)
		sample_valid |-> (state_q == ST_OUTW))
		else $error("sample valid outside output state");

	// the last sample of a pair returns the sequencer to idle
	assert property (@(posedge clk) disable iff (!arst_n)
		(out_xfer && last_of_item) |=> (state_q == ST_IDLE))
		else $error("sequencer not idle after last sample");

	// multiplier results only arrive while the sequencer waits for one
	assert property (@(posedge clk) disable iff (!arst_n)
		mul_done |-> ((state_q == ST_SQ1) || (state_q == ST_SQ2) || (state_q == ST_LOGSQ)
			|| (state_q == ST_LNMUL) || (state_q == ST_SMUL)))
		else $error("unexpected multiplier result");

	// an end of block always closes the pair
	assert property (@(posedge clk) disable iff (!arst_n)
		(sample_valid && end_of_block) |-> last_of_item)
		else $error("end of block without last of item");
`endif

endmodule
